>>> rtl/thresholded_node_degree_counter_assert.svh
// assertion macros used by the degree counter top level
`ifndef THRESHOLDED_NODE_DEGREE_COUNTER_ASSERT_SVH
`define THRESHOLDED_NODE_DEGREE_COUNTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TNDC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TNDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tndc_pkg.sv
package tndc_pkg;

  // default sizes
  localparam int MAX_NODES_DEF   = 1024;
  localparam int DEGREE_BITS_DEF = 16;

  // fixed field widths
  localparam int IDX_W     = 10;
  localparam int VAL_W     = 16;
  localparam int CNT_W     = 11;
  localparam int DEG_OUT_W = 16;
  localparam int CMD_W     = 2;
  localparam int CFG_W     = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // register indexes
  localparam logic CFG_THRESHOLD  = 1'b0;
  localparam logic CFG_NODE_COUNT = 1'b1;

  // register reset values
  localparam logic signed [VAL_W-1:0] THRESHOLD_RESET  = 16'sd0;
  localparam logic        [CNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // classified operation handed to the back end
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ERR,
    OP_READ,
    OP_PEEK,
    OP_BUMP1,
    OP_BUMP2,
    OP_CLEAR
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

>>> rtl/tndc_ram.sv
module tndc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/tndc_queue.sv
module tndc_queue import tndc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t head_o
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

endmodule

>>> rtl/tndc_front.sv
module tndc_front import tndc_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [IDX_W-1:0]        row_index_i,
  input  logic [IDX_W-1:0]        col_index_i,
  input  logic signed [VAL_W-1:0] fc_value_i,
  input  back_status_t            back_status_i,
  input  logic                    queue_full_i,
  output logic                    push_o,
  output item_t                   push_item_o
);

  localparam int NODES_W = $clog2(MAX_NODES + 1);
  localparam int LIM_W   = (NODES_W > CNT_W) ? NODES_W : CNT_W;

  logic signed [VAL_W-1:0] threshold_q;
  logic [CNT_W-1:0]        node_count_q;
  logic [LIM_W-1:0]        count_ext;
  logic [LIM_W-1:0]        lim;
  logic                    row_ok;
  logic                    col_ok;
  logic                    above;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= THRESHOLD_RESET;
      node_count_q <= NODE_COUNT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_THRESHOLD:  threshold_q  <= $signed(cfg_data_i[VAL_W-1:0]);
        CFG_NODE_COUNT: node_count_q <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // effective node count, clamped to the store depth
  assign count_ext = LIM_W'(node_count_q);
  assign lim       = (count_ext > LIM_W'(MAX_NODES)) ? LIM_W'(MAX_NODES) : count_ext;
  assign row_ok    = LIM_W'(row_index_i) < lim;
  assign col_ok    = LIM_W'(col_index_i) < lim;
  assign above     = fc_value_i > threshold_q;

  // classify the incoming transaction
  always_comb begin
    push_item_o.row_index = row_index_i;
    push_item_o.col_index = col_index_i;
    case (command_i)
      CMD_EDGE: begin
        if (!(row_ok && col_ok)) begin
          push_item_o.op = OP_ERR;
        end else if (!above) begin
          push_item_o.op = OP_PEEK;
        end else if (row_index_i == col_index_i) begin
          push_item_o.op = OP_BUMP2;
        end else begin
          push_item_o.op = OP_BUMP1;
        end
      end
      CMD_READ:  push_item_o.op = row_ok ? OP_READ : OP_ERR;
      CMD_CLEAR: push_item_o.op = OP_CLEAR;
      default:   push_item_o.op = OP_NONE;
    endcase
  end

  // hold off input while the queue is full or the store is being swept
  assign in_ready_o = !queue_full_i && !back_status_i.clearing;
  assign push_o     = in_valid_i && in_ready_o;

endmodule

>>> rtl/tndc_back.sv
module tndc_back import tndc_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int DEGREE_BITS = DEGREE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 queue_valid_i,
  input  item_t                queue_head_i,
  output logic                 pop_o,
  output back_status_t         status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [DEG_OUT_W-1:0] degree_first_o,
  output logic [DEG_OUT_W-1:0] degree_second_o,
  output logic                 edge_counted_o,
  output logic                 result_status_o
);

  localparam int ADDR_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int WIDE_W = (DEGREE_BITS > DEG_OUT_W) ? DEGREE_BITS : DEG_OUT_W;

  // sequencer states
  localparam logic [1:0] ST_CLR    = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_FIRST  = 2'd2;
  localparam logic [1:0] ST_SECOND = 2'd3;

  logic [1:0]             state_q, state_d;
  op_e                    op_q, op_d;
  logic [ADDR_W-1:0]      row_q, row_d;
  logic [ADDR_W-1:0]      col_q, col_d;
  logic [ADDR_W-1:0]      clr_addr_q, clr_addr_d;
  logic [DEGREE_BITS-1:0] deg_first_q, deg_first_d;

  logic                   ram_we;
  logic [ADDR_W-1:0]      ram_waddr;
  logic [DEGREE_BITS-1:0] ram_wdata;
  logic [ADDR_W-1:0]      ram_raddr;
  logic [DEGREE_BITS-1:0] ram_rdata;

  logic [1:0]             amount;
  logic [DEGREE_BITS:0]   sum;
  logic [DEGREE_BITS-1:0] sat;

  logic                   emit;
  logic [DEGREE_BITS-1:0] e_first;
  logic [DEGREE_BITS-1:0] e_second;
  logic                   e_counted;
  logic                   e_status;
  logic [WIDE_W-1:0]      first_wide;
  logic [WIDE_W-1:0]      second_wide;

  logic                   out_valid_q, out_valid_d;
  logic [DEG_OUT_W-1:0]   out_first_q;
  logic [DEG_OUT_W-1:0]   out_second_q;
  logic                   out_counted_q;
  logic                   out_status_q;

  tndc_ram #(
    .WIDTH (DEGREE_BITS),
    .DEPTH (MAX_NODES),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // saturating increment of the counter just read
  always_comb begin
    amount = 2'd0;
    if (state_q == ST_FIRST) begin
      case (op_q)
        OP_BUMP1: amount = 2'd1;
        OP_BUMP2: amount = 2'd2;
        default:  amount = 2'd0;
      endcase
    end else if (state_q == ST_SECOND && op_q == OP_BUMP1) begin
      amount = 2'd1;
    end
  end

  assign sum = {1'b0, ram_rdata} + (DEGREE_BITS + 1)'(amount);
  assign sat = sum[DEGREE_BITS] ? '1 : sum[DEGREE_BITS-1:0];

  // sequencer: sweep the store, or read row, then column, write back, report
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    row_d       = row_q;
    col_d       = col_q;
    clr_addr_d  = clr_addr_q;
    deg_first_d = deg_first_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = row_q;
    ram_wdata   = sat;
    ram_raddr   = ADDR_W'(queue_head_i.row_index);
    emit        = 1'b0;
    e_first     = '0;
    e_second    = '0;
    e_counted   = 1'b0;
    e_status    = 1'b0;
    case (state_q)
      ST_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_q;
        ram_wdata = '0;
        if (clr_addr_q == ADDR_W'(MAX_NODES - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_addr_d = clr_addr_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (queue_valid_i && (!out_valid_q || out_ready_i)) begin
          pop_o = 1'b1;
          op_d  = queue_head_i.op;
          row_d = ADDR_W'(queue_head_i.row_index);
          col_d = ADDR_W'(queue_head_i.col_index);
          case (queue_head_i.op)
            OP_ERR: begin
              emit     = 1'b1;
              e_status = 1'b1;
            end
            OP_CLEAR: begin
              emit       = 1'b1;
              clr_addr_d = '0;
              state_d    = ST_CLR;
            end
            OP_READ, OP_PEEK, OP_BUMP1, OP_BUMP2: begin
              state_d = ST_FIRST;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end
      ST_FIRST: begin
        // row counter is on the read port
        ram_raddr = col_q;
        ram_waddr = row_q;
        ram_we    = (op_q == OP_BUMP1) || (op_q == OP_BUMP2);
        if (op_q == OP_READ || op_q == OP_BUMP2) begin
          emit      = 1'b1;
          e_first   = sat;
          e_second  = (op_q == OP_BUMP2) ? sat : '0;
          e_counted = (op_q == OP_BUMP2);
          state_d   = ST_IDLE;
        end else begin
          deg_first_d = sat;
          state_d     = ST_SECOND;
        end
      end
      ST_SECOND: begin
        // column counter is on the read port
        ram_waddr = col_q;
        ram_we    = (op_q == OP_BUMP1);
        emit      = 1'b1;
        e_first   = deg_first_q;
        e_second  = sat;
        e_counted = (op_q == OP_BUMP1);
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLR;
      clr_addr_q <= '0;
      op_q       <= OP_NONE;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      op_q       <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    col_q       <= col_d;
    deg_first_q <= deg_first_d;
  end

  // output register, low bits of each counter
  assign first_wide  = WIDE_W'(e_first);
  assign second_wide = WIDE_W'(e_second);
  assign out_valid_d = emit || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_first_q   <= first_wide[DEG_OUT_W-1:0];
      out_second_q  <= second_wide[DEG_OUT_W-1:0];
      out_counted_q <= e_counted;
      out_status_q  <= e_status;
    end
  end

  assign status_o.clearing = (state_q == ST_CLR);
  assign out_valid_o       = out_valid_q;
  assign degree_first_o    = out_first_q;
  assign degree_second_o   = out_second_q;
  assign edge_counted_o    = out_counted_q;
  assign result_status_o   = out_status_q;

endmodule

>>> rtl/thresholded_node_degree_counter.sv
// Thresholded node degree counter: each transaction is an edge element, a degree read, a
// clear or an unused code, and gives exactly one result. Degrees live in a memory with one
// write and one registered read port, and a sequencer steps through each item against it:
// an in-range edge reads row, then reads column and writes row, then writes column, with
// writes only if it counts; a counted diagonal edge, like a read, ends after the row step,
// and an index error or unused code ends when taken. A clear returns its result at once,
// then sweeps the store's MAX_NODES entries, one entry a cycle; the same sweep runs after
// reset. in_ready_o stays low during a sweep. A two-entry queue between the classifier and
// the sequencer, and an output register, let input and output stall independently.
// Configuration must be written only while the block is idle; nothing enforces it.
`include "thresholded_node_degree_counter_assert.svh"

module thresholded_node_degree_counter import tndc_pkg::*; #(
  parameter int MAX_NODES   = MAX_NODES_DEF,
  parameter int DEGREE_BITS = DEGREE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic                    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [CMD_W-1:0]        command_i,
  input  logic [IDX_W-1:0]        row_index_i,
  input  logic [IDX_W-1:0]        col_index_i,
  input  logic signed [VAL_W-1:0] fc_value_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DEG_OUT_W-1:0]    degree_first_o,
  output logic [DEG_OUT_W-1:0]    degree_second_o,
  output logic                    edge_counted_o,
  output logic                    status_o
);

  logic         push;
  item_t        push_item;
  logic         queue_full;
  logic         queue_valid;
  item_t        queue_head;
  logic         pop;
  back_status_t back_status;
  logic         out_stall;

  // classifier and configuration
  tndc_front #(
    .MAX_NODES(MAX_NODES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .fc_value_i   (fc_value_i),
    .back_status_i(back_status),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  // decoupling queue
  tndc_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_item_i(push_item),
    .full_o     (queue_full),
    .pop_i      (pop),
    .valid_o    (queue_valid),
    .head_o     (queue_head)
  );

  // counter sequencer and output register
  tndc_back #(
    .MAX_NODES  (MAX_NODES),
    .DEGREE_BITS(DEGREE_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .queue_valid_i  (queue_valid),
    .queue_head_i   (queue_head),
    .pop_o          (pop),
    .status_o       (back_status),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .degree_first_o (degree_first_o),
    .degree_second_o(degree_second_o),
    .edge_counted_o (edge_counted_o),
    .result_status_o(status_o)
  );

  // result waiting on the receiver
  assign out_stall = out_valid_o && !out_ready_i;

  // checks on the front to back hand-off and on the result register
  `TNDC_ASSERT_NOW(a_no_accept_in_sweep, clk_i, rst_ni, back_status.clearing, !push, "input in sweep")
  `TNDC_ASSERT_NOW(a_no_pop_empty, clk_i, rst_ni, pop, queue_valid, "pop from empty queue")
  `TNDC_ASSERT_NOW(a_no_push_full, clk_i, rst_ni, push, !queue_full, "push into full queue")
  `TNDC_ASSERT_NEXT(a_stall_holds, clk_i, rst_ni, out_stall, out_valid_o, "result dropped")

endmodule

>>> verif/thresholded_node_degree_counter_tb.sv
module thresholded_node_degree_counter_tb import tndc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NODES          = MAX_NODES_DEF;
  localparam int DEG_W          = DEGREE_BITS_DEF;
  localparam int SETTLE_CYCLES  = MAX_NODES_DEF + 80;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int RANDOM_PHASES  = 6;
  localparam int PHASE_ITEMS    = 170;
  localparam int HOT_NODE       = 5;
  localparam int HOT_EDGES      = 40;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  // clock, reset and block inputs, all known from time zero
  logic                    clk_i           = 1'b0;
  logic                    rst_ni          = 1'b0;
  logic                    cfg_we_i        = 1'b0;
  logic                    cfg_index_i     = CFG_THRESHOLD;
  logic [CFG_W-1:0]        cfg_data_i      = '0;
  logic                    in_valid_i      = 1'b0;
  logic [CMD_W-1:0]        command_i       = CMD_EDGE;
  logic [IDX_W-1:0]        row_index_i     = '0;
  logic [IDX_W-1:0]        col_index_i     = '0;
  logic signed [VAL_W-1:0] fc_value_i      = '0;
  logic                    out_ready_i     = 1'b0;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic [DEG_OUT_W-1:0]    degree_first_o;
  logic [DEG_OUT_W-1:0]    degree_second_o;
  logic                    edge_counted_o;
  logic                    status_o;

  typedef struct packed {
    logic [DEG_OUT_W-1:0] deg_row;
    logic [DEG_OUT_W-1:0] deg_col;
    logic                 counted;
    logic                 flagged;
  } degree_result_t;

  // mirror of the degree store and registers, plus the queue of awaited results
  class degree_scoreboard;
    logic [DEG_W-1:0]        store [NODES];
    logic signed [VAL_W-1:0] threshold;
    logic [CNT_W-1:0]        node_count;
    degree_result_t          awaited[$];
    int                      mismatches;
    int                      compared;
    int                      counted_edges;
    int                      flagged_items;

    function new();
      foreach (store[i]) store[i] = '0;
      threshold     = THRESHOLD_RESET;
      node_count    = NODE_COUNT_RESET;
      mismatches    = 0;
      compared      = 0;
      counted_edges = 0;
      flagged_items = 0;
    endfunction

    function void set_threshold(logic [CFG_W-1:0] word);
      threshold = word[VAL_W-1:0];
    endfunction

    function void set_node_count(logic [CFG_W-1:0] word);
      node_count = word[CNT_W-1:0];
    endfunction

    function int unsigned active_limit();
      return (node_count > NODES) ? NODES : node_count;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // saturating counter increment
    function void bump(int idx, int unsigned amount);
      longint unsigned sum;
      longint unsigned top;
      top = (longint'(1) << DEG_W) - 1;
      sum = longint'(store[idx]) + amount;
      if (sum > top) sum = top;
      store[idx] = sum[DEG_W-1:0];
    endfunction

    function void note_input(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] row,
                             logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] val);
      degree_result_t r;
      int unsigned    lim;
      r   = '0;
      lim = active_limit();
      case (cmd)
        CMD_EDGE: begin
          if (row >= lim || col >= lim) begin
            r.flagged = 1'b1;
          end else begin
            if (val > threshold) begin
              if (row == col) begin
                bump(row, 2);
              end else begin
                bump(row, 1);
                bump(col, 1);
              end
              r.counted = 1'b1;
            end
            r.deg_row = store[row];
            r.deg_col = store[col];
          end
        end
        CMD_READ: begin
          if (row >= lim) r.flagged = 1'b1;
          else r.deg_row = store[row];
        end
        CMD_CLEAR: begin
          foreach (store[i]) store[i] = '0;
        end
        default: ;
      endcase
      if (r.counted) counted_edges++;
      if (r.flagged) flagged_items++;
      awaited.push_back(r);
    endfunction

    function void check_result(degree_result_t got);
      degree_result_t exp;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing awaited: first %0d second %0d counted %0b status %0b",
                 $time, got.deg_row, got.deg_col, got.counted, got.flagged);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      compared++;
      if (got.deg_row !== exp.deg_row) begin
        $display("%0t: degree_first expected %0d actual %0d", $time, exp.deg_row, got.deg_row);
        mismatches++;
      end
      if (got.deg_col !== exp.deg_col) begin
        $display("%0t: degree_second expected %0d actual %0d", $time, exp.deg_col, got.deg_col);
        mismatches++;
      end
      if (got.counted !== exp.counted) begin
        $display("%0t: edge_counted expected %0b actual %0b", $time, exp.counted, got.counted);
        mismatches++;
      end
      if (got.flagged !== exp.flagged) begin
        $display("%0t: status expected %0b actual %0b", $time, exp.flagged, got.flagged);
        mismatches++;
      end
    endfunction
  endclass

  degree_scoreboard sb = new();

  int sender_idle_pct   = 0;
  int receiver_idle_pct = 0;
  int holdoff_req       = 0;
  int holdoff_seen      = 0;
  int holdoff_left      = 0;
  int items_sent        = 0;
  int settings_used     = 0;

  thresholded_node_degree_counter uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .row_index_i    (row_index_i),
    .col_index_i    (col_index_i),
    .fc_value_i     (fc_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .degree_first_o (degree_first_o),
    .degree_second_o(degree_second_o),
    .edge_counted_o (edge_counted_o),
    .status_o       (status_o)
  );

  // 20 ns clock
  always #10 clk_i = ~clk_i;

  // result side: check each transaction, then decide the next ready
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result('{degree_first_o, degree_second_o, edge_counted_o, status_o});
    end
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  // run limit
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col, input logic signed [VAL_W-1:0] val);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    command_i   <= cmd;
    row_index_i <= row;
    col_index_i <= col;
    fc_value_i  <= val;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, row, col, val);
    items_sent++;
  endtask

  task automatic wait_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // all results in, then let any clear sweep finish
  task automatic settle_idle();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] thr_word,
                              input logic [CFG_W-1:0] nodes_word);
    settle_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_THRESHOLD;
    cfg_data_i  <= thr_word;
    @(posedge clk_i);
    sb.set_threshold(thr_word);
    cfg_index_i <= CFG_NODE_COUNT;
    cfg_data_i  <= nodes_word;
    @(posedge clk_i);
    sb.set_node_count(nodes_word);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic logic [IDX_W-1:0] pick_node();
    int unsigned lim;
    int unsigned r;
    lim = sb.active_limit();
    r   = $urandom_range(0, 99);
    if (lim == 0 || r < 10) return IDX_W'($urandom);
    if (r < 18) return IDX_W'((lim <= 1023 && r < 14) ? lim : lim - 1);
    if (r < 50) return IDX_W'($urandom_range(0, ((lim < 8) ? lim : 8) - 1));
    return IDX_W'($urandom_range(0, lim - 1));
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      v = int'(sb.threshold) + int'($urandom_range(0, 2)) - 1;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return VAL_W'(v);
    end
    if (r < 35) return (r < 30) ? 16'sh8000 : 16'sh7FFF;
    return VAL_W'($urandom);
  endfunction

  task automatic send_random_item();
    int unsigned      r;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    r   = $urandom_range(0, 99);
    cmd = (r < 62) ? CMD_EDGE : (r < 91) ? CMD_READ : (r < 94) ? CMD_CLEAR : CMD_UNUSED;
    row = pick_node();
    col = ($urandom_range(0, 9) == 0) ? row : pick_node();
    send_item(cmd, row, col, pick_value());
  endtask

  initial begin
    // reset, then the post-reset sweep is covered by the settle in write_config
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, diagonal, threshold boundary, unused code, clear
    write_config(16'h0000, 16'd1024);
    send_item(CMD_READ, 10'd0, 10'd0, 16'sd0);
    send_item(CMD_EDGE, 10'd0, 10'd1023, 16'sh7FFF);
    send_item(CMD_EDGE, 10'd1023, 10'd0, 16'sh8000);
    send_item(CMD_EDGE, 10'd5, 10'd5, 16'sd1);
    send_item(CMD_EDGE, 10'd7, 10'd8, 16'sd0);
    send_item(CMD_EDGE, 10'd7, 10'd8, 16'sd1);
    send_item(CMD_READ, 10'd1023, 10'd1023, 16'shFFFF);
    send_item(CMD_UNUSED, 10'h3FF, 10'h3FF, 16'shFFFF);
    send_item(CMD_EDGE, 10'd1023, 10'd1023, 16'sh7FFF);
    send_item(CMD_CLEAR, 10'd0, 10'd0, 16'sd0);
    send_item(CMD_READ, 10'd1023, 10'd0, 16'sd0);
    // small node count: out of range on either index
    write_config(16'h0000, 16'd10);
    send_item(CMD_EDGE, 10'd9, 10'd10, 16'sd100);
    send_item(CMD_EDGE, 10'd10, 10'd9, 16'sd100);
    send_item(CMD_EDGE, 10'd9, 10'd9, 16'sd100);
    send_item(CMD_READ, 10'd10, 10'd0, 16'sd0);
    send_item(CMD_READ, 10'd9, 10'd0, 16'sd0);
    // zero nodes: everything flagged
    write_config(16'h0000, 16'd0);
    send_item(CMD_EDGE, 10'd0, 10'd0, 16'sh7FFF);
    send_item(CMD_READ, 10'd0, 10'd0, 16'sd0);
    // count above the maximum clamps, lowest threshold
    write_config(16'h8000, 16'd2047);
    send_item(CMD_EDGE, 10'd1023, 10'd0, 16'sh8000);
    send_item(CMD_EDGE, 10'd1023, 10'd0, 16'sh8001);
    send_item(CMD_READ, 10'd1023, 10'd0, 16'sd0);
    // highest threshold: nothing can count
    write_config(16'h7FFF, 16'd1024);
    send_item(CMD_EDGE, 10'd3, 10'd4, 16'sh7FFF);
    send_item(CMD_READ, 10'd3, 10'd0, 16'sd0);

    // random phases over several settings and idling modes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_config(16'h0000, 16'd1024);
        1: write_config(16'h8000, 16'd16);
        2: write_config(16'h7FFF, 16'd1);
        3: write_config(CFG_W'($urandom), 16'd2047);
        4: write_config(CFG_W'($urandom), {5'($urandom_range(1, 31)), 11'd300});
        default: write_config(-16'sd1000, 16'd40);
      endcase
      case (p / 2)
        0: begin sender_idle_pct = 34; receiver_idle_pct = 46; end
        1: begin sender_idle_pct = 46; receiver_idle_pct = 34; end
        default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (p == 1) begin
        sender_idle_pct = 0;
        holdoff_req++;
        repeat (30) send_random_item();
        sender_idle_pct = 34;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2 && p == 3) wait_results();
        send_random_item();
      end
    end

    // repeated diagonal edges on one node, at full rate
    write_config(16'h8000, 16'd1024);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    send_item(CMD_CLEAR, 10'd0, 10'd0, 16'sd0);
    settle_idle();
    for (int i = 0; i < HOT_EDGES; i++) begin
      send_item(CMD_EDGE, IDX_W'(HOT_NODE), IDX_W'(HOT_NODE),
                VAL_W'($urandom_range(0, 32767)));
    end
    send_item(CMD_EDGE, IDX_W'(HOT_NODE), IDX_W'(HOT_NODE + 1), 16'sd1);
    send_item(CMD_READ, IDX_W'(HOT_NODE), 10'd0, 16'sd0);

    settle_idle();
    $display("%0d transactions sent over %0d register settings, %0d results compared",
             items_sent, settings_used, sb.compared);
    $display("%0d edges counted, %0d items flagged out of range, %0d diagonal edges on node %0d",
             sb.counted_edges, sb.flagged_items, HOT_EDGES, HOT_NODE);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/tndc_pkg.sv
rtl/tndc_ram.sv
rtl/tndc_queue.sv
rtl/tndc_front.sv
rtl/tndc_back.sv
rtl/thresholded_node_degree_counter.sv
verif/thresholded_node_degree_counter_tb.sv
